// ----- src/sra_pkg.sv -----
// sra_pkg: constants, codes and control/status structs of the staging ring allocator
// used by the channel interfaces, the controller, the datapath and the top level
package sra_pkg;

  localparam int TASK_SLOTS   = 8;
  localparam int SLOT_W       = $clog2(TASK_SLOTS);
  localparam int COUNT_W      = $clog2(TASK_SLOTS + 1);
  localparam int RESULT_LIMIT = 8;
  localparam int LIMIT_W      = $clog2(RESULT_LIMIT + 1);
  localparam int ALIGN_BYTES  = 512;

  localparam int BYTE_W       = 32;
  localparam int FENCE_W      = 64;
  localparam int OP_W         = 2;
  localparam int SLOT_FIELD_W = 3;
  localparam int DIV_CNT_W    = $clog2(BYTE_W + 2);

  localparam int CFG_INDEX_W  = 1;
  localparam int CFG_DATA_W   = 32;

  localparam logic [BYTE_W-1:0]  DEFAULT_RING_BYTES = BYTE_W'(64 * 1024 * 1024);
  localparam logic [FENCE_W-1:0] NOT_FENCED         = '1;
  localparam logic [BYTE_W:0]    ALIGN_ADD          = (BYTE_W + 1)'(ALIGN_BYTES - 1);
  localparam logic [BYTE_W:0]    ALIGN_MASK         = ~ALIGN_ADD;

  localparam logic [CFG_INDEX_W-1:0] CFG_UPLOAD_RING   = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_READBACK_RING = 1'b1;

  typedef enum logic [1:0] {
    OP_ALLOC  = 2'd0,
    OP_SUBMIT = 2'd1,
    OP_RETIRE = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_ALLOC  = 2'd0,
    KIND_SUBMIT = 2'd1,
    KIND_RETIRE = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_SLOT = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef struct packed {
    logic take_in;
    logic aln;
    logic place;
    logic alloc_emit;
    logic submit_emit;
    logic pend_emit;
    logic ret_sum;
    logic div_step;
    logic ret_commit;
  } sra_cmd_t;

  typedef struct packed {
    logic out_free;
    logic ret_elig;
    logic pend_valid;
    logic fast;
    logic div_done;
  } sra_stat_t;

endpackage

// ----- src/sra_if.sv -----
// sra_in_if and sra_out_if: valid/ready channels for request and result items
// depends on sra_pkg for field widths
interface sra_in_if;
  import sra_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         op;
  logic [BYTE_W-1:0]       byte_size;
  logic                    direction;
  logic [SLOT_FIELD_W-1:0] task_slot;
  logic [FENCE_W-1:0]      completed_fence;

  modport source (output valid, op, byte_size, direction, task_slot, completed_fence,
                  input ready);
  modport sink (input valid, op, byte_size, direction, task_slot, completed_fence,
                output ready);
endinterface

interface sra_out_if;
  import sra_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [1:0]              kind;
  logic [1:0]              status;
  logic [SLOT_FIELD_W-1:0] slot_out;
  logic [BYTE_W-1:0]       ring_offset;
  logic [BYTE_W-1:0]       aligned_size;
  logic [FENCE_W-1:0]      fence_out;
  logic                    last;

  modport source (output valid, kind, status, slot_out, ring_offset, aligned_size,
                  fence_out, last, input ready);
  modport sink (input valid, kind, status, slot_out, ring_offset, aligned_size,
                fence_out, last, output ready);
endinterface

// ----- src/sra_ctrl.sv -----
// sra_ctrl: sequencing state machine for allocate, submit and in-order retirement
// depends on sra_pkg for op codes and the command/status structs
module sra_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic [sra_pkg::OP_W-1:0]      in_op,
  output logic                          in_ready,
  input  sra_pkg::sra_stat_t            stat,
  output sra_pkg::sra_cmd_t             cmd
);
  import sra_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_ALN   = 9'b000000010,
    S_PLACE = 9'b000000100,
    S_ADONE = 9'b000001000,
    S_SUB   = 9'b000010000,
    S_RCHK  = 9'b000100000,
    S_RSUM  = 9'b001000000,
    S_RDIV  = 9'b010000000,
    S_RCOM  = 9'b100000000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    in_ready   = (state == S_IDLE);
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take_in = 1'b1;
          case (in_op)
            OP_ALLOC:  state_next = S_ALN;
            OP_SUBMIT: state_next = S_SUB;
            OP_RETIRE: state_next = S_RCHK;
            default:   state_next = S_IDLE;
          endcase
        end
      end
      S_ALN: begin
        cmd.aln    = 1'b1;
        state_next = S_PLACE;
      end
      S_PLACE: begin
        cmd.place  = 1'b1;
        state_next = S_ADONE;
      end
      S_ADONE: begin
        if (stat.out_free) begin
          cmd.alloc_emit = 1'b1;
          state_next     = S_IDLE;
        end
      end
      S_SUB: begin
        if (stat.out_free) begin
          cmd.submit_emit = 1'b1;
          state_next      = S_IDLE;
        end
      end
      S_RCHK: begin
        // the held notice goes out once we know whether another follows
        if (!stat.pend_valid || stat.out_free) begin
          cmd.pend_emit = stat.pend_valid;
          state_next    = stat.ret_elig ? S_RSUM : S_IDLE;
        end
      end
      S_RSUM: begin
        cmd.ret_sum = 1'b1;
        state_next  = S_RDIV;
      end
      S_RDIV: begin
        if (stat.fast || stat.div_done) begin
          state_next = S_RCOM;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_RCOM: begin
        cmd.ret_commit = 1'b1;
        state_next     = S_RCHK;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ----- src/sra_dp.sv -----
// sra_dp: ring pointers, task table, fence counter, remainder unit and result register
// depends on sra_pkg; driven by sra_ctrl commands
module sra_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [sra_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [sra_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic [sra_pkg::BYTE_W-1:0]          in_byte_size,
  input  logic                                in_direction,
  input  logic [sra_pkg::SLOT_FIELD_W-1:0]    in_task_slot,
  input  logic [sra_pkg::FENCE_W-1:0]         in_completed_fence,
  input  sra_pkg::sra_cmd_t                   cmd,
  output sra_pkg::sra_stat_t                  stat,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic [1:0]                          out_kind,
  output logic [1:0]                          out_status,
  output logic [sra_pkg::SLOT_FIELD_W-1:0]    out_slot,
  output logic [sra_pkg::BYTE_W-1:0]          out_offset,
  output logic [sra_pkg::BYTE_W-1:0]          out_length,
  output logic [sra_pkg::FENCE_W-1:0]         out_fence,
  output logic                                out_last
);
  import sra_pkg::*;

  // configuration and ring pointers
  logic [BYTE_W-1:0] upload_bytes;
  logic [BYTE_W-1:0] readback_bytes;
  logic [BYTE_W-1:0] ring_start [2];
  logic [BYTE_W-1:0] ring_end   [2];

  // task table
  logic [BYTE_W-1:0]  t_offset [TASK_SLOTS];
  logic [BYTE_W-1:0]  t_length [TASK_SLOTS];
  logic [FENCE_W-1:0] t_fence  [TASK_SLOTS];
  logic               t_ring   [TASK_SLOTS];
  logic [SLOT_W-1:0]  head;
  logic [COUNT_W-1:0] count;
  logic [FENCE_W-1:0] fence_ctr;

  // captured item
  logic [BYTE_W-1:0]       size_r;
  logic                    dir_r;
  logic [SLOT_FIELD_W-1:0] slot_r;
  logic [FENCE_W-1:0]      done_r;

  // allocate pipeline
  logic [BYTE_W:0] n_r;
  logic [BYTE_W:0] esum;
  logic            s_le_e;
  logic            n_le_s;

  // retirement
  logic [LIMIT_W-1:0]   k;
  logic [BYTE_W:0]      dq;
  logic [BYTE_W-1:0]    rem;
  logic [BYTE_W-1:0]    rsize;
  logic                 fast;
  logic [DIV_CNT_W-1:0] div_cnt;

  logic                    pend_valid;
  logic [SLOT_FIELD_W-1:0] pend_slot;
  logic [BYTE_W-1:0]       pend_off;
  logic [BYTE_W-1:0]       pend_len;
  logic [FENCE_W-1:0]      pend_fence;

  // combinational helpers
  logic [BYTE_W-1:0]  ring_bytes_dir;
  logic [BYTE_W-1:0]  s_cur;
  logic [BYTE_W-1:0]  e_cur;
  logic [SLOT_W:0]    tail_sum;
  logic [SLOT_W-1:0]  tail;
  logic [SLOT_W-1:0]  head_inc;
  logic [SLOT_W-1:0]  slot_idx;
  logic [SLOT_W:0]    rel;
  logic               slot_live;
  logic               elig;
  logic               table_full;
  logic               too_big;
  logic [BYTE_W-1:0]  aligned_rep;
  logic               lt_r;
  logic               lt_s;
  logic               place_ok;
  logic               wrap;
  logic               grant;
  logic [BYTE_W-1:0]  pos;
  logic [BYTE_W-1:0]  new_end;
  logic [1:0]         alloc_status;
  logic [FENCE_W-1:0] fence_inc;
  logic [BYTE_W:0]    rsum;
  logic [BYTE_W-1:0]  rsel;
  logic [BYTE_W:0]    trial;
  logic               out_free;

  assign ring_bytes_dir = dir_r ? readback_bytes : upload_bytes;
  assign s_cur          = ring_start[dir_r];
  assign e_cur          = ring_end[dir_r];

  assign tail_sum = (SLOT_W + 1)'(head) + (SLOT_W + 1)'(count);
  assign tail     = (tail_sum >= (SLOT_W + 1)'(TASK_SLOTS))
                    ? SLOT_W'(tail_sum - (SLOT_W + 1)'(TASK_SLOTS)) : SLOT_W'(tail_sum);
  assign head_inc = (head == SLOT_W'(TASK_SLOTS - 1)) ? '0 : head + SLOT_W'(1);

  assign slot_idx = SLOT_W'(slot_r);
  always_comb begin
    if (slot_idx >= head) begin
      rel = (SLOT_W + 1)'(slot_idx) - (SLOT_W + 1)'(head);
    end else begin
      rel = (SLOT_W + 1)'(slot_idx) + (SLOT_W + 1)'(TASK_SLOTS) - (SLOT_W + 1)'(head);
    end
  end
  assign slot_live = (int'(slot_r) < TASK_SLOTS) && (rel < (SLOT_W + 1)'(count));
  assign fence_inc = fence_ctr + FENCE_W'(1);

  assign elig = (count != '0) && (k < LIMIT_W'(RESULT_LIMIT)) && (done_r >= t_fence[head]);

  // placement decision
  assign table_full  = (count >= COUNT_W'(TASK_SLOTS));
  assign too_big     = n_r[BYTE_W];
  assign aligned_rep = too_big ? '1 : n_r[BYTE_W-1:0];
  assign lt_r        = esum < {1'b0, ring_bytes_dir};
  assign lt_s        = esum < {1'b0, s_cur};
  assign place_ok    = s_le_e ? (lt_r || n_le_s) : lt_s;
  assign wrap        = s_le_e && !lt_r;
  assign grant       = !table_full && !too_big && place_ok;
  assign pos         = wrap ? '0 : e_cur;
  assign new_end     = wrap ? n_r[BYTE_W-1:0] : esum[BYTE_W-1:0];

  always_comb begin
    if (table_full) begin
      alloc_status = ST_NO_SLOT;
    end else if (too_big || !place_ok) begin
      alloc_status = ST_FULL;
    end else begin
      alloc_status = ST_OK;
    end
  end

  // new ring start after retiring the head task
  assign rsum  = {1'b0, t_offset[head]} + {1'b0, t_length[head]};
  assign rsel  = t_ring[head] ? readback_bytes : upload_bytes;
  assign trial = {rem, dq[BYTE_W]};

  assign out_free = !out_valid || out_ready;

  assign stat.out_free   = out_free;
  assign stat.ret_elig   = elig;
  assign stat.pend_valid = pend_valid;
  assign stat.fast       = fast;
  assign stat.div_done   = (div_cnt == '0);

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      upload_bytes   <= DEFAULT_RING_BYTES;
      readback_bytes <= DEFAULT_RING_BYTES;
      for (int i = 0; i < 2; i++) begin
        ring_start[i] <= '0;
        ring_end[i]   <= '0;
      end
      head       <= '0;
      count      <= '0;
      fence_ctr  <= '0;
      k          <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_UPLOAD_RING:   upload_bytes   <= BYTE_W'(cfg_data);
          CFG_READBACK_RING: readback_bytes <= BYTE_W'(cfg_data);
          default: ;
        endcase
      end
      if (cmd.take_in) begin
        k          <= '0;
        pend_valid <= 1'b0;
      end
      if (cmd.alloc_emit && grant) begin
        ring_end[dir_r] <= new_end;
        count           <= count + COUNT_W'(1);
      end
      if (cmd.submit_emit && slot_live) begin
        fence_ctr <= fence_inc;
      end
      if (cmd.pend_emit) begin
        pend_valid <= 1'b0;
      end
      if (cmd.ret_commit) begin
        ring_start[t_ring[head]] <= rem;
        head       <= head_inc;
        count      <= count - COUNT_W'(1);
        k          <= k + LIMIT_W'(1);
        pend_valid <= 1'b1;
      end
      if (cmd.alloc_emit || cmd.submit_emit || cmd.pend_emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      size_r <= in_byte_size;
      dir_r  <= in_direction;
      slot_r <= in_task_slot;
      done_r <= in_completed_fence;
    end
    if (cmd.aln) begin
      n_r <= ({1'b0, size_r} + ALIGN_ADD) & ALIGN_MASK;
    end
    if (cmd.place) begin
      esum   <= {1'b0, e_cur} + n_r;
      s_le_e <= s_cur <= e_cur;
      n_le_s <= n_r <= {1'b0, s_cur};
    end
    if (cmd.alloc_emit && grant) begin
      t_offset[tail] <= pos;
      t_length[tail] <= n_r[BYTE_W-1:0];
      t_fence[tail]  <= NOT_FENCED;
      t_ring[tail]   <= dir_r;
    end
    if (cmd.submit_emit && slot_live) begin
      t_fence[slot_idx] <= fence_inc;
    end
    if (cmd.ret_sum) begin
      rsize   <= rsel;
      dq      <= rsum;
      div_cnt <= DIV_CNT_W'(BYTE_W + 1);
      if (rsel == '0) begin
        fast <= 1'b1;
        rem  <= '0;
      end else if (rsum < {1'b0, rsel}) begin
        fast <= 1'b1;
        rem  <= rsum[BYTE_W-1:0];
      end else begin
        fast <= 1'b0;
        rem  <= '0;
      end
    end
    if (cmd.div_step) begin
      // restoring remainder, one dividend bit a cycle
      if (trial >= {1'b0, rsize}) begin
        rem <= BYTE_W'(trial - {1'b0, rsize});
      end else begin
        rem <= trial[BYTE_W-1:0];
      end
      dq      <= {dq[BYTE_W-1:0], 1'b0};
      div_cnt <= div_cnt - DIV_CNT_W'(1);
    end
    if (cmd.ret_commit) begin
      pend_slot  <= SLOT_FIELD_W'(head);
      pend_off   <= t_offset[head];
      pend_len   <= t_length[head];
      pend_fence <= t_fence[head];
    end
    if (cmd.alloc_emit) begin
      out_kind   <= KIND_ALLOC;
      out_status <= alloc_status;
      out_slot   <= grant ? SLOT_FIELD_W'(tail) : '0;
      out_offset <= grant ? pos : '0;
      out_length <= aligned_rep;
      out_fence  <= '0;
      out_last   <= 1'b1;
    end else if (cmd.submit_emit) begin
      out_kind   <= KIND_SUBMIT;
      out_status <= slot_live ? ST_OK : ST_NO_SLOT;
      out_slot   <= slot_r;
      out_offset <= '0;
      out_length <= '0;
      out_fence  <= slot_live ? fence_inc : '0;
      out_last   <= 1'b1;
    end else if (cmd.pend_emit) begin
      out_kind   <= KIND_RETIRE;
      out_status <= ST_OK;
      out_slot   <= pend_slot;
      out_offset <= pend_off;
      out_length <= pend_len;
      out_fence  <= pend_fence;
      out_last   <= !elig;
    end
  end

endmodule

// ----- src/staging_ring_allocator_with_fence_retire.sv -----
// staging_ring_allocator_with_fence_retire: upload/readback ring allocator with fence retirement
// one item at a time; allocate aligns, places and then emits its result, submit emits directly, op 3 gives none
// retirement: each retired task is summed, reduced modulo its ring size and committed; the remainder
// unit (33 steps) runs only when the end of the task reaches the ring size; up to 8 tasks per item
// synchronous active-high reset clears pointers, counters and handshake state, no clearing pass
// depends on sra_pkg, sra_if, sra_ctrl, sra_dp
module staging_ring_allocator_with_fence_retire (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [sra_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [sra_pkg::CFG_DATA_W-1:0]    cfg_data,
  sra_in_if.sink                            req,
  sra_out_if.source                         rsp
);
  import sra_pkg::*;

  sra_cmd_t  cmd;
  sra_stat_t stat;
  logic      in_ready;

  assign req.ready = in_ready;

  sra_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_op    (req.op),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sra_dp u_dp (
    .clk                (clk),
    .rst                (rst),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_byte_size       (req.byte_size),
    .in_direction       (req.direction),
    .in_task_slot       (req.task_slot),
    .in_completed_fence (req.completed_fence),
    .cmd                (cmd),
    .stat               (stat),
    .out_ready          (rsp.ready),
    .out_valid          (rsp.valid),
    .out_kind           (rsp.kind),
    .out_status         (rsp.status),
    .out_slot           (rsp.slot_out),
    .out_offset         (rsp.ring_offset),
    .out_length         (rsp.aligned_size),
    .out_fence          (rsp.fence_out),
    .out_last           (rsp.last)
  );

endmodule
